// File: hdl/gdjs_pkg.sv
// Package for the greedy deadline job scheduler: sizes, field widths,
// controller states and the command/status structs shared by all modules.
// No dependencies.
`default_nettype none

package gdjs_pkg;

	// Batch capacity and slot range
	localparam int NUM_JOBS  = 8;
	localparam int MAX_SLOTS = 64;

	// Derived index and count widths
	localparam int IDX_W  = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
	localparam int CNT_W  = $clog2(NUM_JOBS + 1);
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// Field widths
	localparam int PROFIT_W = 16;
	localparam int DL_W     = 8;
	localparam int TOTAL_W  = 19;
	localparam int SCHED_W  = 4;

	// Controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // job request accepted
		logic start;  // batch closed, set up scheduling
		logic scan;   // compare one stored job against the current best
		logic place;  // put the best job into a slot
		logic emit;   // load the result register and clear the batch
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_last;  // scan index is at the last loaded job
		logic rank_last;  // this rank is the last one of the batch
		logic out_busy;   // result register holds a request not taken now
	} sts_t;

endpackage

`default_nettype wire

// File: hdl/gdjs_if.sv
// Valid/ready channel interfaces for job requests and result requests.
// Depends on gdjs_pkg for field widths.
`default_nettype none

interface gdjs_job_if;
	logic                         valid;
	logic                         ready;
	logic [gdjs_pkg::PROFIT_W-1:0] job_profit;
	logic [gdjs_pkg::DL_W-1:0]     job_deadline;
	logic                         last_job;

	modport source (output valid, job_profit, job_deadline, last_job, input ready);
	modport sink   (input valid, job_profit, job_deadline, last_job, output ready);
endinterface

interface gdjs_res_if;
	logic                         valid;
	logic                         ready;
	logic [gdjs_pkg::TOTAL_W-1:0] total_profit;
	logic [gdjs_pkg::SCHED_W-1:0] jobs_scheduled;
	logic [gdjs_pkg::DL_W-1:0]    largest_deadline;
	logic                         batch_overflow;

	modport source (output valid, total_profit, jobs_scheduled, largest_deadline,
		batch_overflow, input ready);
	modport sink   (input valid, total_profit, jobs_scheduled, largest_deadline,
		batch_overflow, output ready);
endinterface

`default_nettype wire

// File: hdl/gdjs_ctrl.sv
// Controller for the job scheduler: load, scan, place and emit sequencing.
// Depends on gdjs_pkg (state_t, cmd_t, sts_t).
`default_nettype none

module gdjs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	input  wire logic            job_last,
	output logic                 job_ready,
	output gdjs_pkg::cmd_t       cmd,
	input  wire gdjs_pkg::sts_t  sts
);

	gdjs_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdjs_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gdjs_pkg::ST_LOAD: begin
				if (job_valid && job_last) state_nxt = gdjs_pkg::ST_SCAN;
			end
			gdjs_pkg::ST_SCAN: begin
				if (sts.scan_last) state_nxt = gdjs_pkg::ST_PLACE;
			end
			gdjs_pkg::ST_PLACE: begin
				state_nxt = sts.rank_last ? gdjs_pkg::ST_EMIT : gdjs_pkg::ST_SCAN;
			end
			gdjs_pkg::ST_EMIT: begin
				if (!sts.out_busy) state_nxt = gdjs_pkg::ST_LOAD;
			end
			default: state_nxt = gdjs_pkg::ST_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		job_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			gdjs_pkg::ST_LOAD: begin
				job_ready = 1'b1;
				cmd.load  = job_valid;
				cmd.start = job_valid && job_last;
			end
			gdjs_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			gdjs_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
			end
			gdjs_pkg::ST_EMIT: begin
				cmd.emit = !sts.out_busy;
			end
			default: begin
				job_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/gdjs_dp.sv
// Datapath for the job scheduler: job stores, best-job scan, slot map,
// accumulators and the result register. Depends on gdjs_pkg.
`default_nettype none

module gdjs_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gdjs_pkg::cmd_t                cmd,
	output gdjs_pkg::sts_t                     sts,
	input  wire logic [gdjs_pkg::PROFIT_W-1:0] job_profit,
	input  wire logic [gdjs_pkg::DL_W-1:0]     job_deadline,
	input  wire logic                          res_ready,
	output logic                               res_valid,
	output logic [gdjs_pkg::TOTAL_W-1:0]       total_profit,
	output logic [gdjs_pkg::SCHED_W-1:0]       jobs_scheduled,
	output logic [gdjs_pkg::DL_W-1:0]          largest_deadline,
	output logic                               batch_overflow
);

	// Job stores
	logic [gdjs_pkg::PROFIT_W-1:0] profit_mem_q   [gdjs_pkg::NUM_JOBS];
	logic [gdjs_pkg::DL_W-1:0]     deadline_mem_q [gdjs_pkg::NUM_JOBS];

	// Batch bookkeeping
	logic [gdjs_pkg::CNT_W-1:0]   cnt_q;
	logic                         ovf_q;
	logic [gdjs_pkg::DL_W-1:0]    maxd_q;

	// Scheduling state
	logic [gdjs_pkg::IDX_W-1:0]    scan_q;
	logic [gdjs_pkg::CNT_W-1:0]    rank_q;
	logic [gdjs_pkg::NUM_JOBS-1:0] picked_q;
	logic                          best_vld_q;
	logic [gdjs_pkg::IDX_W-1:0]    best_idx_q;
	logic [gdjs_pkg::PROFIT_W-1:0] best_p_q;
	logic [gdjs_pkg::DL_W-1:0]     best_d_q;
	logic [gdjs_pkg::MAX_SLOTS-1:0] slots_q;
	logic [gdjs_pkg::TOTAL_W-1:0]  total_q;
	logic [gdjs_pkg::SCHED_W-1:0]  placed_q;

	// Result register
	logic                         res_vld_q;
	logic [gdjs_pkg::TOTAL_W-1:0] res_total_q;
	logic [gdjs_pkg::SCHED_W-1:0] res_sched_q;
	logic [gdjs_pkg::DL_W-1:0]    res_maxd_q;
	logic                         res_ovf_q;

	logic                          room;
	logic [gdjs_pkg::PROFIT_W-1:0] rd_p;
	logic [gdjs_pkg::DL_W-1:0]     rd_d;
	logic                          take;
	logic [gdjs_pkg::DL_W-1:0]     lim;
	logic                          hit;
	logic [gdjs_pkg::SLOT_W-1:0]   hit_idx;

	assign room = (cnt_q < gdjs_pkg::CNT_W'(gdjs_pkg::NUM_JOBS));
	assign rd_p = profit_mem_q[scan_q];
	assign rd_d = deadline_mem_q[scan_q];

	// Strict compare keeps the earliest job on equal profit
	assign take = !picked_q[scan_q] && (!best_vld_q || (rd_p > best_p_q));

	// Clamp the deadline to the slot range
	assign lim = (best_d_q > gdjs_pkg::DL_W'(gdjs_pkg::MAX_SLOTS))
		? gdjs_pkg::DL_W'(gdjs_pkg::MAX_SLOTS) : best_d_q;

	// Find the latest free slot at or below the clamped deadline (bit i is slot i+1)
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < gdjs_pkg::MAX_SLOTS; i++) begin
			if (!slots_q[i] && (i < int'(lim))) begin
				hit     = 1'b1;
				hit_idx = gdjs_pkg::SLOT_W'(i);
			end
		end
	end

	// Status
	assign sts.scan_last = (gdjs_pkg::CNT_W'(scan_q) == cnt_q - 1'b1);
	assign sts.rank_last = (rank_q == cnt_q - 1'b1);
	assign sts.out_busy  = res_vld_q && !res_ready;

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			profit_mem_q[cnt_q[gdjs_pkg::IDX_W-1:0]]   <= job_profit;
			deadline_mem_q[cnt_q[gdjs_pkg::IDX_W-1:0]] <= job_deadline;
		end
	end

	// Track count, overflow and largest deadline; clear on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			maxd_q <= '0;
		end else if (cmd.emit) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			maxd_q <= '0;
		end else if (cmd.load) begin
			if (room) begin
				cnt_q <= cnt_q + 1'b1;
				if (job_deadline > maxd_q) maxd_q <= job_deadline;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Scan, place and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			rank_q     <= '0;
			picked_q   <= '0;
			best_vld_q <= 1'b0;
			slots_q    <= '0;
			total_q    <= '0;
			placed_q   <= '0;
		end else if (cmd.start) begin
			scan_q     <= '0;
			rank_q     <= '0;
			picked_q   <= '0;
			best_vld_q <= 1'b0;
			slots_q    <= '0;
			total_q    <= '0;
			placed_q   <= '0;
		end else if (cmd.scan) begin
			scan_q <= scan_q + 1'b1;
			if (take) best_vld_q <= 1'b1;
		end else if (cmd.place) begin
			picked_q[best_idx_q] <= 1'b1;
			if (hit) begin
				slots_q[hit_idx] <= 1'b1;
				total_q  <= gdjs_pkg::TOTAL_W'(total_q + best_p_q);
				placed_q <= placed_q + 1'b1;
			end
			rank_q     <= rank_q + 1'b1;
			scan_q     <= '0;
			best_vld_q <= 1'b0;
		end
	end

	// Hold the best candidate of the current scan
	always_ff @(posedge clk) begin
		if (cmd.scan && take) begin
			best_idx_q <= scan_q;
			best_p_q   <= rd_p;
			best_d_q   <= rd_d;
		end
	end

	// Result valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_total_q <= total_q;
			res_sched_q <= placed_q;
			res_maxd_q  <= maxd_q;
			res_ovf_q   <= ovf_q;
		end
	end

	assign res_valid        = res_vld_q;
	assign total_profit     = res_total_q;
	assign jobs_scheduled   = res_sched_q;
	assign largest_deadline = res_maxd_q;
	assign batch_overflow   = res_ovf_q;

endmodule

`default_nettype wire

// File: hdl/greedy_deadline_job_scheduler_top.sv
// After the request that carries last_job, the batch runs one rank per stored job (at most 8):
// per rank, a scan over every stored job, then a place step; the emit state then loads the result.
// Throughput: jobs load one per cycle; no jobs are taken while a batch is scheduled
// or while the emit cycle waits for a previous result that is not yet taken.
// Reset: arst_n clears the batch, the slot map and the result valid; stores are not reset.
// Depends on gdjs_pkg, gdjs_if, gdjs_ctrl and gdjs_dp.
`default_nettype none

module greedy_deadline_job_scheduler_top (
	input  wire logic clk,
	input  wire logic arst_n,
	gdjs_job_if.sink  job,
	gdjs_res_if.source res
);

	gdjs_pkg::cmd_t cmd;
	gdjs_pkg::sts_t sts;

	// Controller
	gdjs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_last  (job.last_job),
		.job_ready (job.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath
	gdjs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.job_profit       (job.job_profit),
		.job_deadline     (job.job_deadline),
		.res_ready        (res.ready),
		.res_valid        (res.valid),
		.total_profit     (res.total_profit),
		.jobs_scheduled   (res.jobs_scheduled),
		.largest_deadline (res.largest_deadline),
		.batch_overflow   (res.batch_overflow)
	);

	// Emit never overwrites a result that is not being taken
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("emit while result register busy");

	// Emit always presents a result next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res.valid)
		else $error("result not valid after emit");

	// A new result only appears after an emit
	a_rose_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(cmd.emit))
		else $error("result valid without emit");

	// Placement lasts one cycle per rank
	a_place_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |=> !cmd.place)
		else $error("place held for two cycles");

endmodule

`default_nettype wire
